>>> rtl/feod_pkg.sv
package feod_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;          // |sample| <= 32768
  localparam int SQ_W     = 2 * MAG_W - 1; // 32768^2 = 2^30
  localparam int ENERGY_W = 41;
  localparam int ROOT_W   = (ENERGY_W + 1) / 2;
  localparam int REM_W    = ENERGY_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 1'b0,
    REG_ENABLED = 1'b1
  } cfg_reg_t;

  localparam logic MODE_ENVELOPE = 1'b0;
  localparam logic MODE_DIFF     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_SQRT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

>>> rtl/feod_if.sv
interface feod_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [feod_pkg::SAMPLE_W-1:0] sample;
  logic                               frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface feod_onset_if;
  logic                         valid;
  logic                         ready;
  logic [feod_pkg::ENERGY_W-1:0] onset_value;

  modport source (output valid, output onset_value, input ready);
  modport sink   (input valid, input onset_value, output ready);
endinterface

interface feod_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [feod_pkg::CFG_IDX_W-1:0] index;
  logic                          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/feod_sqrt.sv
// Bit-serial floor square root: one result bit per cycle.
module feod_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [feod_pkg::ENERGY_W-1:0] value,
  output feod_pkg::sqrt_stat_t          stat,
  output logic [feod_pkg::ROOT_W-1:0]   root
);

  logic [feod_pkg::REM_W-1:0] rem;
  logic [feod_pkg::REM_W-1:0] acc_root;
  logic [feod_pkg::REM_W-1:0] bit_pos;
  logic [feod_pkg::REM_W-1:0] trial;
  logic                       busy;
  logic                       done;

  assign trial = acc_root + bit_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && bit_pos[0];
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bit_pos[0]) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, value};
      acc_root <= '0;
      // highest even bit position below REM_W
      bit_pos  <= {{(feod_pkg::REM_W-1){1'b0}}, 1'b1} << (2 * (feod_pkg::ROOT_W - 1));
    end else if (busy) begin
      if (rem >= trial) begin
        rem      <= rem - trial;
        acc_root <= (acc_root >> 1) + bit_pos;
      end else begin
        acc_root <= acc_root >> 1;
      end
      bit_pos <= bit_pos >> 2;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign root      = acc_root[feod_pkg::ROOT_W-1:0];

endmodule

>>> rtl/frame_energy_onset_detector.sv
// Channel   Dir  Role    Payload
// samples   in   sink    sample (s16), frame_end
// onsets    out  source  onset_value (u41), one item per frame end
// cfg       in   sink    index (0 mode, 1 enabled), data (1 bit); always ready
//
// Enabled sample: accept, square, accumulate.
// Frame end, difference mode: accept, square, accumulate, result; envelope mode
//   adds the bit-serial square root, one result bit per iteration, before the result.
// Disabled: plain samples are only accepted; a frame end is accepted, then reported.
// Reset (rst, sync): mode = difference, disabled, energies cleared.
// A result waits in the output register; the next item is taken meanwhile and
//   only a second result stalls until the first is taken.
module frame_energy_onset_detector (
  input  logic         clk,
  input  logic         rst,
  feod_sample_if.sink  samples,
  feod_onset_if.source onsets,
  feod_cfg_if.sink     cfg
);

  feod_pkg::state_t state;
  feod_pkg::state_t state_next;

  logic                          mode;
  logic                          enabled;
  logic [feod_pkg::MAG_W-1:0]    mag;
  logic                          last;
  logic [feod_pkg::SQ_W-1:0]     sq;
  logic [feod_pkg::ENERGY_W-1:0] acc;
  logic [feod_pkg::ENERGY_W-1:0] prev;
  logic [feod_pkg::ENERGY_W-1:0] res;
  logic                          out_valid;
  logic [feod_pkg::ENERGY_W-1:0] out_data;

  logic                          in_fire;
  logic                          out_load;
  logic                          sqrt_start;
  logic [feod_pkg::ENERGY_W:0]   sum;
  logic [feod_pkg::ENERGY_W-1:0] energy;
  logic [feod_pkg::MAG_W-1:0]    in_mag;
  feod_pkg::sqrt_stat_t          sq_stat;
  logic [feod_pkg::ROOT_W-1:0]   sq_root;

  // config port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= feod_pkg::MODE_DIFF;
      enabled <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        feod_pkg::REG_MODE:    mode    <= cfg.data;
        feod_pkg::REG_ENABLED: enabled <= cfg.data;
        default: ;
      endcase
    end
  end

  assign in_fire = samples.valid && samples.ready;

  // two's complement magnitude; -32768 maps to 32768 in 16 unsigned bits
  assign in_mag = samples.sample[feod_pkg::SAMPLE_W-1]
                  ? feod_pkg::MAG_W'(-samples.sample) : feod_pkg::MAG_W'(samples.sample);

  // saturating accumulate
  assign sum    = {1'b0, acc} + {{(feod_pkg::ENERGY_W + 1 - feod_pkg::SQ_W){1'b0}}, sq};
  assign energy = sum[feod_pkg::ENERGY_W] ? feod_pkg::ENERGY_MAX
                                          : sum[feod_pkg::ENERGY_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      feod_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (enabled)                 state_next = feod_pkg::ST_SQUARE;
          else if (samples.frame_end)  state_next = feod_pkg::ST_RESULT;
        end
      end
      feod_pkg::ST_SQUARE: state_next = feod_pkg::ST_ACCUM;
      feod_pkg::ST_ACCUM: begin
        if (!last)                                  state_next = feod_pkg::ST_IDLE;
        else if (mode == feod_pkg::MODE_ENVELOPE)   state_next = feod_pkg::ST_SQRT;
        else                                        state_next = feod_pkg::ST_RESULT;
      end
      feod_pkg::ST_SQRT: begin
        if (sq_stat.done) state_next = feod_pkg::ST_RESULT;
      end
      feod_pkg::ST_RESULT: begin
        if (!out_valid || onsets.ready) state_next = feod_pkg::ST_IDLE;
      end
      default: state_next = feod_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    samples.ready = 1'b0;
    sqrt_start    = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      feod_pkg::ST_IDLE:   samples.ready = 1'b1;
      feod_pkg::ST_SQUARE: ;
      feod_pkg::ST_ACCUM:  sqrt_start = last && (mode == feod_pkg::MODE_ENVELOPE);
      feod_pkg::ST_SQRT:   ;
      feod_pkg::ST_RESULT: out_load = !out_valid || onsets.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= feod_pkg::ST_IDLE;
      acc       <= '0;
      prev      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == feod_pkg::ST_ACCUM) begin
        if (last) begin
          acc <= '0;
          if (mode == feod_pkg::MODE_DIFF) prev <= energy;
        end else begin
          acc <= energy;
        end
      end
      if (out_load)          out_valid <= 1'b1;
      else if (onsets.ready) out_valid <= 1'b0;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag  <= in_mag;
      last <= samples.frame_end;
      res  <= '0;                      // disabled frame end reports zero
    end
    if (state == feod_pkg::ST_SQUARE) begin
      sq <= feod_pkg::SQ_W'(mag * mag);
    end
    if (state == feod_pkg::ST_ACCUM && mode == feod_pkg::MODE_DIFF) begin
      res <= (energy > prev) ? energy - prev : '0;
    end
    if (state == feod_pkg::ST_SQRT && sq_stat.done) begin
      res <= {{(feod_pkg::ENERGY_W - feod_pkg::ROOT_W){1'b0}}, sq_root};
    end
    if (out_load) out_data <= res;
  end

  feod_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (energy),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  assign onsets.valid       = out_valid;
  assign onsets.onset_value = out_data;

`ifndef SYNTH
  a_sqrt_start_free: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> !sq_stat.busy)
    else $error("square root started while busy");

  a_sqrt_in_state: assert property (@(posedge clk) disable iff (rst)
    (state == feod_pkg::ST_SQRT) |-> (sq_stat.busy || sq_stat.done))
    else $error("waiting on idle square root unit");

  a_frame_clears_acc: assert property (@(posedge clk) disable iff (rst)
    (state == feod_pkg::ST_ACCUM && last) |=> (acc == '0))
    else $error("accumulator not cleared at frame end");

  a_disabled_holds: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !enabled) |=> ($stable(acc) && $stable(prev)))
    else $error("state changed while disabled");
`endif

endmodule
